>>> src/announce_egress_scheduler_macros.svh
// Assertion helpers used by the scheduler datapath.
`ifndef ANNOUNCE_EGRESS_SCHEDULER_MACROS_SVH
`define ANNOUNCE_EGRESS_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AES_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AES_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/aes_pkg.sv
package aes_pkg;

    localparam int NOW_W     = 40;
    localparam int HOP_W     = 8;
    localparam int LEN_W     = 10;
    localparam int TAG_W     = 8;
    localparam int ORD_W     = 16;
    localparam int STAT_W    = 3;
    localparam int CNT5_W    = 5;
    localparam int DRAIN_W   = 32;
    localparam int BR_W      = 27;
    localparam int CAP_W     = 16;
    localparam int LIFE_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BITRATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE    = 2'd2;

    localparam logic [BR_W-1:0]   BITRATE_RST = 27'd0;
    localparam logic [CAP_W-1:0]  CAP_RST     = 16'd1310;
    localparam logic [LIFE_W-1:0] LIFE_RST    = 32'd86400000;

    localparam logic [STAT_W-1:0] STAT_NONE     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_ACCEPTED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RELEASED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_GATED    = 3'd4;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Airtime in ms is len * 8 bits * 1000 ms * 2^16 / (bitrate * cap).
    localparam int              AIR_SCALE_W = 13;
    localparam logic [12:0]     AIR_SCALE   = 13'd8000;
    localparam int              Q_SHIFT     = 16;
    localparam int              NUM_W       = 40;
    localparam int              DEN_W       = BR_W + CAP_W;
    localparam int              DIV_BITS    = 2;
    localparam int              DIV_STEPS   = NUM_W / DIV_BITS;
    localparam int              DIV_CNT_W   = 5;

    typedef struct packed {
        logic              command;
        logic [NOW_W-1:0]  now_ms;
        logic [HOP_W-1:0]  hop_count;
        logic [LEN_W-1:0]  byte_length;
        logic [TAG_W-1:0]  packet_tag;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [TAG_W-1:0]   released_tag;
        logic [HOP_W-1:0]   released_hops;
        logic [LEN_W-1:0]   released_length;
        logic [CNT5_W-1:0]  entries_left;
        logic [CNT5_W-1:0]  expired_count;
        logic [DRAIN_W-1:0] drained_total;
        logic [NOW_W-1:0]   next_allowed_ms;
    } out_item_t;

    typedef struct packed {
        logic [HOP_W-1:0] hops;
        logic [NOW_W-1:0] stamp;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
        logic [ORD_W-1:0] order;
    } slot_t;

    typedef struct packed {
        logic              capture;
        logic              idx_clear;
        logic              idx_inc;
        logic              enq_write;
        logic              scan_issue;
        logic              release_slot;
        logic              div_start;
        logic              div_step;
        logic              set_allowed;
        logic              out_load;
        logic [STAT_W-1:0] status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic count_zero;
        logic slot_free;
        logic idx_last;
        logic gated;
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

>>> src/aes_divider.sv
module aes_divider
    import aes_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              step,
    input  logic [LEN_W-1:0]  len,
    input  logic [BR_W-1:0]   bitrate,
    input  logic [CAP_W-1:0]  cap,
    output logic              done,
    output logic [NOW_W-1:0]  quotient
);

    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W:0]       rem_reg, rem_next;
    logic                 zero_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [LEN_W+AIR_SCALE_W-1:0] scaled_len;

    assign scaled_len = (LEN_W+AIR_SCALE_W)'(len) * (LEN_W+AIR_SCALE_W)'(AIR_SCALE);

    // Restoring division, two quotient bits per cycle; the quotient shifts into num_reg.
    always_comb begin
        rem_next = rem_reg;
        num_next = num_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            rem_next = {rem_next[DEN_W-1:0], num_next[NUM_W-1]};
            num_next = {num_next[NUM_W-2:0], 1'b0};
            if (rem_next >= {1'b0, den_reg}) begin
                rem_next    = rem_next - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end else if (start) begin
            cnt_reg <= '0;
        end else if (step && cnt_reg != DIV_CNT_W'(DIV_STEPS)) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= NUM_W'({scaled_len, {Q_SHIFT{1'b0}}});
            den_reg  <= DEN_W'(bitrate) * DEN_W'(cap);
            zero_reg <= (bitrate == '0) || (cap == '0);
            rem_reg  <= '0;
        end else if (step && cnt_reg != DIV_CNT_W'(DIV_STEPS)) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = (cnt_reg == DIV_CNT_W'(DIV_STEPS));
    assign quotient = zero_reg ? '0 : num_reg;

endmodule

>>> src/aes_datapath.sv
`include "announce_egress_scheduler_macros.svh"

module aes_datapath
    import aes_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  in_item_t             s_item,
    output out_item_t            m_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  ctrl_cmd_t            cmd,
    output ctrl_sts_t            sts
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = $bits(slot_t);

    logic [BR_W-1:0]   bitrate_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [LIFE_W-1:0] life_reg;

    in_item_t                 item_reg;
    logic [IW-1:0]            idx_reg;
    logic [QUEUE_DEPTH-1:0]   valid_reg, valid_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            exp_reg, exp_next;
    logic [MW-1:0]            mem [QUEUE_DEPTH];
    logic [MW-1:0]            rd_data_reg;
    logic [IW-1:0]            rd_idx_reg;
    logic                     eval_pend_reg;
    logic                     best_valid_reg;
    logic [IW-1:0]            best_idx_reg;
    slot_t                    best_reg;
    logic [ORD_W-1:0]         seq_reg;
    logic [NOW_W-1:0]         allowed_reg;
    logic [DRAIN_W-1:0]       drained_reg;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    slot_t            ent;
    logic             ent_valid;
    logic             ent_expired;
    logic             ent_better;
    logic [NOW_W:0]   expire_at;
    logic [ORD_W-1:0] age_ent;
    logic [ORD_W-1:0] age_best;
    logic             div_done;
    logic [NOW_W-1:0] quotient;
    logic [NOW_W:0]   allowed_sum;
    slot_t            new_slot;

    aes_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .len      (best_reg.len),
        .bitrate  (bitrate_reg),
        .cap      (cap_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitrate_reg <= BITRATE_RST;
            cap_reg     <= CAP_RST;
            life_reg    <= LIFE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BITRATE: bitrate_reg <= cfg_wdata[BR_W-1:0];
                CFG_CAP:     cap_reg     <= cfg_wdata[CAP_W-1:0];
                CFG_LIFE:    life_reg    <= cfg_wdata[LIFE_W-1:0];
                default:     ;
            endcase
        end
    end

    assign ent         = slot_t'(rd_data_reg);
    assign ent_valid   = eval_pend_reg && valid_reg[rd_idx_reg];
    assign expire_at   = {1'b0, ent.stamp} + (NOW_W+1)'(life_reg);
    assign ent_expired = {1'b0, item_reg.now_ms} > expire_at;
    assign age_ent     = seq_reg - ent.order;
    assign age_best    = seq_reg - best_reg.order;
    // Lower hop count wins, then the older timestamp, then the earlier insertion.
    assign ent_better  = !best_valid_reg
                       || (ent.hops < best_reg.hops)
                       || ((ent.hops == best_reg.hops)
                           && ((ent.stamp < best_reg.stamp)
                               || ((ent.stamp == best_reg.stamp) && (age_ent > age_best))));

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        exp_next   = exp_reg;
        if (cmd.capture) begin
            exp_next = '0;
        end
        if (cmd.enq_write) begin
            valid_next[idx_reg] = 1'b1;
            count_next          = count_reg + 1'b1;
        end
        if (ent_valid && ent_expired) begin
            valid_next[rd_idx_reg] = 1'b0;
            count_next             = count_reg - 1'b1;
            exp_next               = exp_reg + 1'b1;
        end
        if (cmd.release_slot) begin
            valid_next[best_idx_reg] = 1'b0;
            count_next               = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            count_reg      <= '0;
            exp_reg        <= '0;
            seq_reg        <= '0;
            allowed_reg    <= '0;
            drained_reg    <= '0;
            eval_pend_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            exp_reg       <= exp_next;
            eval_pend_reg <= cmd.scan_issue;
            if (cmd.enq_write) begin
                seq_reg <= seq_reg + 1'b1;
            end
            if (cmd.release_slot) begin
                drained_reg <= drained_reg + 1'b1;
            end
            if (cmd.set_allowed) begin
                allowed_reg <= allowed_sum[NOW_W] ? {NOW_W{1'b1}} : allowed_sum[NOW_W-1:0];
            end
            if (cmd.capture) begin
                best_valid_reg <= 1'b0;
            end else if (ent_valid && !ent_expired && ent_better) begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign allowed_sum = {1'b0, item_reg.now_ms} + {1'b0, quotient};

    assign new_slot.hops  = item_reg.hop_count;
    assign new_slot.stamp = item_reg.now_ms;
    assign new_slot.len   = item_reg.byte_length;
    assign new_slot.tag   = item_reg.packet_tag;
    assign new_slot.order = seq_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.enq_write) begin
            mem[idx_reg] <= new_slot;
        end
        if (cmd.scan_issue) begin
            rd_data_reg <= mem[idx_reg];
            rd_idx_reg  <= idx_reg;
        end
        if (ent_valid && !ent_expired && ent_better) begin
            best_reg     <= ent;
            best_idx_reg <= rd_idx_reg;
        end
        if (cmd.out_load) begin
            out_reg.status <= cmd.status;
            if (cmd.status == STAT_RELEASED) begin
                out_reg.released_tag    <= best_reg.tag;
                out_reg.released_hops   <= best_reg.hops;
                out_reg.released_length <= best_reg.len;
            end else begin
                out_reg.released_tag    <= '0;
                out_reg.released_hops   <= '0;
                out_reg.released_length <= '0;
            end
            out_reg.entries_left    <= CNT5_W'(count_reg);
            out_reg.expired_count   <= CNT5_W'(exp_reg);
            out_reg.drained_total   <= drained_reg;
            out_reg.next_allowed_ms <= allowed_reg;
        end
    end

    assign sts.is_tick    = (item_reg.command == CMD_TICK);
    assign sts.count_zero = (count_reg == '0);
    assign sts.slot_free  = !valid_reg[idx_reg];
    assign sts.idx_last   = (idx_reg == IW'(QUEUE_DEPTH - 1));
    assign sts.gated      = (item_reg.now_ms < allowed_reg);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !out_valid_reg || m_ready;

    assign m_item  = out_reg;
    assign m_valid = out_valid_reg;

    `AES_ASSERT_IMPLIES(a_count_matches, aclk, aresetn, 1'b1,
        count_reg == CW'($countones(valid_reg)), "entry count differs from valid slots")
    `AES_ASSERT_IMPLIES(a_no_overwrite, aclk, aresetn, cmd.out_load,
        !out_valid_reg || m_ready, "result loaded over one not yet taken")
    `AES_ASSERT_NEXT(a_release_counts, aclk, aresetn, cmd.release_slot,
        drained_reg == $past(drained_reg) + 32'd1, "release not counted")

endmodule

>>> src/aes_controller.sv
module aes_controller
    import aes_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_FIND     = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_SCAN_END = 8'b0001_0000,
        S_DECIDE   = 8'b0010_0000,
        S_DIV      = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        stat_next  = stat_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture   = 1'b1;
                    cmd.idx_clear = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!sts.is_tick) begin
                    state_next = S_FIND;
                end else if (sts.count_zero) begin
                    stat_next  = STAT_NONE;
                    state_next = S_OUT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_FIND: begin
                if (sts.slot_free) begin
                    cmd.enq_write = 1'b1;
                    stat_next     = STAT_ACCEPTED;
                    state_next    = S_OUT;
                end else if (sts.idx_last) begin
                    stat_next  = STAT_DROPPED;
                    state_next = S_OUT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                cmd.idx_inc    = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // The last slot read is evaluated in this cycle.
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.count_zero) begin
                    stat_next  = STAT_NONE;
                    state_next = S_OUT;
                end else if (sts.gated) begin
                    stat_next  = STAT_GATED;
                    state_next = S_OUT;
                end else begin
                    cmd.release_slot = 1'b1;
                    cmd.div_start    = 1'b1;
                    state_next       = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.set_allowed = 1'b1;
                    stat_next       = STAT_RELEASED;
                    state_next      = S_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                cmd.status = stat_reg;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            stat_reg  <= STAT_NONE;
        end else begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

>>> src/announce_egress_scheduler.sv
// Announce egress scheduler: queues announces and releases them at a paced rate.
// Input channel s_valid/s_ready/s_item carries one item, either an enqueue
// (command low) or a tick carrying the current time (command high).
// Result channel m_valid/m_ready/m_item returns exactly one result per item.
// The configuration port writes bitrate, airtime share or lifetime at cfg_addr
// whenever cfg_wr_en is high; the user must use it only while the block is idle (not enforced here).
// One item is processed at a time. An enqueue searches the valid bits
// sequentially for a free slot. A tick scans the slot memory, one read per
// cycle, and when an entry is released it then runs the pacing divider, which
// retires two quotient bits per cycle; a tick on an empty queue skips the scan.
// The result sits in an output register, so s_ready returns high once it is
// loaded, even while the receiver stalls; a further item then waits in its
// last step until the register is free.
// Synchronous reset empties the queue and clears the counters and the pacing
// time; no clearing pass is needed.
module announce_egress_scheduler
    import aes_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    aes_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    aes_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .m_item    (m_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
